// File: hw/rtl/aes_block_encrypt_unit_assert.svh
// Assertion macros shared by the block's checker.
`ifndef AES_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
`define AES_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
`define AES_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/aes_pkg.sv
// Package with the AES payload types, S-box and round helpers.
package aes_pkg;
  localparam int unsigned MaxRounds = 14;
  localparam int unsigned LatencyCycles = MaxRounds + 1;
  localparam logic [3:0] Rounds128 = 4'd10;
  localparam logic [3:0] Rounds256 = 4'd14;

  typedef enum logic [2:0] {
    REG_KEY_WORD_0 = 3'd0,
    REG_KEY_WORD_1 = 3'd1,
    REG_KEY_WORD_2 = 3'd2,
    REG_KEY_WORD_3 = 3'd3,
    REG_KEY_SIZE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } aes_out_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] v);
    return {sbox(v[31:24]), sbox(v[23:16]), sbox(v[15:8]), sbox(v[7:0])};
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0: r = 8'h01;
      4'd1: r = 8'h02;
      4'd2: r = 8'h04;
      4'd3: r = 8'h08;
      4'd4: r = 8'h10;
      4'd5: r = 8'h20;
      4'd6: r = 8'h40;
      4'd7: r = 8'h80;
      4'd8: r = 8'h1b;
      4'd9: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // One round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] o [16];
    logic [127:0] res;
    for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[c*4 + i] = sbox(b[((c + i) % 4)*4 + i]);
    for (int c = 0; c < 4; c++) begin
      if (last) begin
        for (int i = 0; i < 4; i++) o[c*4 + i] = t[c*4 + i];
      end else begin
        o[c*4]   = dbl(t[c*4]) ^ dbl(t[c*4+1]) ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
        o[c*4+1] = t[c*4] ^ dbl(t[c*4+1]) ^ dbl(t[c*4+2]) ^ t[c*4+2] ^ t[c*4+3];
        o[c*4+2] = t[c*4] ^ t[c*4+1] ^ dbl(t[c*4+2]) ^ dbl(t[c*4+3]) ^ t[c*4+3];
        o[c*4+3] = dbl(t[c*4]) ^ t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ dbl(t[c*4+3]);
      end
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = o[i];
    return res ^ k;
  endfunction
endpackage

// File: hw/rtl/aes_key_sched.sv
// Round key schedule, expanded one round key per cycle after reset and each key write.
module aes_key_sched (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  logic [255:0] key,
  input  logic         key_size,
  output logic         busy,
  output logic [127:0] round_key [15]
);
  import aes_pkg::*;

  logic [127:0] rk_r [15];
  logic [127:0] prev_r;
  logic [127:0] prev2_r;
  logic [7:0]   rcon_r;
  logic [3:0]   rnd_r;
  logic         exp_r;
  logic [3:0]   last_rnd;
  logic         use_rcon;
  logic [127:0] base;
  logic [31:0]  t;
  logic [31:0]  w0;
  logic [31:0]  w1;
  logic [31:0]  w2;
  logic [31:0]  w3;
  logic [127:0] rk_nxt;

  assign last_rnd = key_size ? Rounds256 : Rounds128;
  assign use_rcon = !(key_size && rnd_r[0]);
  assign base = key_size ? prev2_r : prev_r;
  assign t = use_rcon ? (sbox_word({prev_r[23:0], prev_r[31:24]}) ^ {rcon_r, 24'h0})
                      : sbox_word(prev_r[31:0]);
  assign w0 = base[127:96] ^ t;
  assign w1 = base[95:64] ^ w0;
  assign w2 = base[63:32] ^ w1;
  assign w3 = base[31:0] ^ w2;
  assign rk_nxt = {w0, w1, w2, w3};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= 1'b1;
      rnd_r <= '0;
    end else if (load) begin
      exp_r <= 1'b1;
      rnd_r <= '0;
    end else if (exp_r) begin
      if (rnd_r == '0) begin
        rnd_r <= key_size ? 4'd2 : 4'd1;
      end else if (rnd_r == last_rnd) begin
        exp_r <= 1'b0;
      end else begin
        rnd_r <= rnd_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exp_r) begin
      if (rnd_r == '0) begin
        rk_r[0] <= key[255:128];
        rk_r[1] <= key[127:0];
        prev2_r <= key[255:128];
        prev_r <= key_size ? key[127:0] : key[255:128];
        rcon_r <= 8'h01;
      end else begin
        rk_r[rnd_r] <= rk_nxt;
        prev2_r <= prev_r;
        prev_r <= rk_nxt;
        if (use_rcon) rcon_r <= dbl(rcon_r);
      end
    end
  end

  assign busy = exp_r;
  assign round_key = rk_r;
endmodule

// File: hw/rtl/aes_block_encrypt_unit.sv
// AES-128/256 encryption core, one round per pipeline stage.
// A block passes every stage register, st_r[0] to st_r[14], for both key sizes.
// Throughput: one block per cycle while busy is low; AES-128 blocks pass the last four stages unchanged.
// After reset and after every configuration write, busy stays high while the round keys are
// expanded; the receiver cannot stall.
// Reset clears the key registers, key size and all stage valid bits.
module aes_block_encrypt_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  aes_pkg::aes_in_t  in_data,
  output logic              out_valid,
  output aes_pkg::aes_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_wdata
);
  import aes_pkg::*;

  logic [63:0] key_r [4];
  logic key_size_r;
  logic [127:0] round_key [15];
  logic [127:0] st_r [15];
  logic [14:0] vld_r;
  logic ks_busy;

  aes_key_sched u_ks (
    .clk(clk), .rst_n(rst_n), .load(cfg_we),
    .key({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .key_size(key_size_r), .busy(ks_busy), .round_key(round_key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      key_size_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_WORD_0: key_r[0] <= cfg_wdata;
        REG_KEY_WORD_1: key_r[1] <= cfg_wdata;
        REG_KEY_WORD_2: key_r[2] <= cfg_wdata;
        REG_KEY_WORD_3: key_r[3] <= cfg_wdata;
        REG_KEY_SIZE:   key_size_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign busy = ks_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[13:0], start && !busy};
  end

  always_ff @(posedge clk) begin
    st_r[0] <= {in_data.block_hi, in_data.block_lo} ^ round_key[0];
    for (int r = 1; r < 15; r++) begin
      if (!key_size_r && r > 10) st_r[r] <= st_r[r-1];
      else st_r[r] <= enc_round(st_r[r-1], round_key[r],
                                key_size_r ? (r == 14) : (r == 10));
    end
  end

  assign out_valid = vld_r[14];
  assign out_data = {st_r[14][127:64], st_r[14][63:0]};
endmodule

// File: hw/rtl/aes_block_encrypt_unit_chk.sv
// Port checker for the AES encryption unit, bound to aes_block_encrypt_unit.
`include "aes_block_encrypt_unit_assert.svh"
module aes_block_encrypt_unit_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_we
);
  logic [14:0] hist_r;
  always_ff @(posedge clk) begin
    if (!rst_n) hist_r <= '0;
    else hist_r <= {hist_r[13:0], start && !busy};
  end
  `AES_ASSERT_NEXT(a_busy_after_cfg, clk, rst_n, cfg_we, busy)
  `AES_ASSERT_IMPL(a_out_matches_in, clk, rst_n, 1'b1, out_valid == hist_r[14])
  `AES_ASSERT_NEXT(a_idle_no_out, clk, rst_n, hist_r[13:0] == 14'd0 && !(start && !busy), !out_valid)
endmodule

bind aes_block_encrypt_unit aes_block_encrypt_unit_chk u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .cfg_we(cfg_we)
);
